// ===== rtl/core/nnis_pkg.sv =====
package nnis_pkg;

  // Fixed point: steps carry 16 fraction bits.
  localparam int unsigned FRAC_BITS  = 16;

  // Register and field widths.
  localparam int unsigned SRC_DIM_W  = 9;
  localparam int unsigned DST_DIM_W  = 13;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned PIXEL_W    = 3 * COLOR_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = DST_DIM_W;

  // Derived datapath widths.
  localparam int unsigned STEP_W  = SRC_DIM_W + FRAC_BITS;
  localparam int unsigned PROD_W  = DST_DIM_W + STEP_W;
  localparam int unsigned COORD_W = PROD_W - FRAC_BITS;

  // Defaults for the top-level parameters and the reset dimensions.
  localparam int unsigned DEF_MAX_SRC_WIDTH  = 256;
  localparam int unsigned DEF_MAX_SRC_HEIGHT = 256;
  localparam int unsigned DEF_MAX_DST_SIZE   = 4096;
  localparam int unsigned DIM_RESET          = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_TARGET_WIDTH  = 3'd2,
    REG_TARGET_HEIGHT = 3'd3
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_FETCH = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    S_COL_START,
    S_COL_WAIT,
    S_ROW_START,
    S_ROW_WAIT,
    S_IDLE,
    S_MUL,
    S_CLAMP,
    S_ADDR,
    S_READ,
    S_DELIVER
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic in_ready;
    logic in_take;
    logic div_start;
    logic div_row;
    logic col_step_load;
    logic row_step_load;
    logic mul_en;
    logic clamp_en;
    logic addr_en;
    logic read_en;
    logic out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic cfg_hit;
    logic in_valid;
    logic in_fetch;
    logic frame_full;
    logic div_busy;
    logic out_free;
  } status_t;

  // A zero dimension counts as one, a dimension above its maximum as the maximum.
  function automatic logic [SRC_DIM_W-1:0] clamp_src(input logic [SRC_DIM_W-1:0] v,
                                                     input int unsigned maxv);
    logic [SRC_DIM_W-1:0] r;
    if (v == '0) begin
      r = SRC_DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = SRC_DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [DST_DIM_W-1:0] clamp_dst(input logic [DST_DIM_W-1:0] v,
                                                     input int unsigned maxv);
    logic [DST_DIM_W-1:0] r;
    if (v == '0) begin
      r = DST_DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DST_DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/nnis_if.sv =====
interface nnis_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [nnis_pkg::COLOR_W-1:0]  red_in;
  logic [nnis_pkg::COLOR_W-1:0]  green_in;
  logic [nnis_pkg::COLOR_W-1:0]  blue_in;

  modport source (output valid, func, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

interface nnis_out_if;
  logic                          valid;
  logic                          ready;
  logic [nnis_pkg::COLOR_W-1:0]  red_out;
  logic [nnis_pkg::COLOR_W-1:0]  green_out;
  logic [nnis_pkg::COLOR_W-1:0]  blue_out;
  logic                          row_end;
  logic                          frame_end;

  modport source (output valid, red_out, green_out, blue_out, row_end, frame_end,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, row_end, frame_end,
                  output ready);
endinterface

// ===== rtl/core/nnis_div.sv =====
// Restoring divider, one quotient bit per cycle.
module nnis_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [nnis_pkg::STEP_W-1:0]   num,
  input  logic [nnis_pkg::DST_DIM_W-1:0] den,
  output logic                          busy,
  output logic [nnis_pkg::STEP_W-1:0]   quo
);

  localparam int unsigned NW    = nnis_pkg::STEP_W;
  localparam int unsigned DW    = nnis_pkg::DST_DIM_W;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    num_r;
  logic [DW-1:0]    den_r;
  logic [DW-1:0]    rem_r;
  logic [NW-1:0]    quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_sub;
  logic             fits;
  logic [DW-1:0]    rem_nxt;

  assign rem_sh  = {rem_r, num_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign fits    = (rem_sh >= {1'b0, den_r});
  // The remainder stays below the divisor, so it fits the divisor's width.
  assign rem_nxt = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/core/nnis_ctrl.sv =====
// Sequencer: step computation after reset or a dimension write, then
// one load per cycle or one fetch through the lookup pipeline.
module nnis_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  nnis_pkg::status_t   sts,
  output nnis_pkg::cmd_t      cmd
);

  nnis_pkg::state_t state_r;
  nnis_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nnis_pkg::S_COL_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (sts.cfg_hit) begin
      state_nxt = nnis_pkg::S_COL_START;
    end else begin
      case (state_r)
        nnis_pkg::S_COL_START: state_nxt = nnis_pkg::S_COL_WAIT;
        nnis_pkg::S_COL_WAIT: begin
          if (!sts.div_busy) state_nxt = nnis_pkg::S_ROW_START;
        end
        nnis_pkg::S_ROW_START: state_nxt = nnis_pkg::S_ROW_WAIT;
        nnis_pkg::S_ROW_WAIT: begin
          if (!sts.div_busy) state_nxt = nnis_pkg::S_IDLE;
        end
        nnis_pkg::S_IDLE: begin
          if (sts.in_valid && sts.in_fetch && sts.frame_full) begin
            state_nxt = nnis_pkg::S_MUL;
          end
        end
        nnis_pkg::S_MUL:   state_nxt = nnis_pkg::S_CLAMP;
        nnis_pkg::S_CLAMP: state_nxt = nnis_pkg::S_ADDR;
        nnis_pkg::S_ADDR:  state_nxt = nnis_pkg::S_READ;
        nnis_pkg::S_READ:  state_nxt = nnis_pkg::S_DELIVER;
        nnis_pkg::S_DELIVER: begin
          if (sts.out_free) state_nxt = nnis_pkg::S_IDLE;
        end
        default: state_nxt = nnis_pkg::S_COL_START;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    if (!sts.cfg_hit) begin
      case (state_r)
        nnis_pkg::S_COL_START: cmd.div_start = 1'b1;
        nnis_pkg::S_COL_WAIT:  cmd.col_step_load = !sts.div_busy;
        nnis_pkg::S_ROW_START: begin
          cmd.div_start = 1'b1;
          cmd.div_row   = 1'b1;
        end
        nnis_pkg::S_ROW_WAIT: begin
          cmd.div_row       = 1'b1;
          cmd.row_step_load = !sts.div_busy;
        end
        nnis_pkg::S_IDLE: begin
          cmd.in_ready = 1'b1;
          cmd.in_take  = sts.in_valid;
        end
        nnis_pkg::S_MUL:     cmd.mul_en   = 1'b1;
        nnis_pkg::S_CLAMP:   cmd.clamp_en = 1'b1;
        nnis_pkg::S_ADDR:    cmd.addr_en  = 1'b1;
        nnis_pkg::S_READ:    cmd.read_en  = 1'b1;
        nnis_pkg::S_DELIVER: cmd.out_load = sts.out_free;
        default: cmd = '0;
      endcase
    end
  end

endmodule

// ===== rtl/core/nnis_datapath.sv =====
// Dimension and step registers, counters, the frame store, the coordinate
// mapping pipeline and the output register.
module nnis_datapath #(
  parameter int unsigned MAX_SRC_WIDTH  = nnis_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = nnis_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned MAX_DST_SIZE   = nnis_pkg::DEF_MAX_DST_SIZE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_func,
  input  logic [nnis_pkg::COLOR_W-1:0]    in_red,
  input  logic [nnis_pkg::COLOR_W-1:0]    in_green,
  input  logic [nnis_pkg::COLOR_W-1:0]    in_blue,
  input  nnis_pkg::cmd_t                  cmd,
  output nnis_pkg::status_t               sts,
  nnis_out_if.source                      out_ch
);

  localparam int unsigned SW     = nnis_pkg::SRC_DIM_W;
  localparam int unsigned DW     = nnis_pkg::DST_DIM_W;
  localparam int unsigned STW    = nnis_pkg::STEP_W;
  localparam int unsigned PW     = nnis_pkg::PROD_W;
  localparam int unsigned CW     = nnis_pkg::COORD_W;
  localparam int unsigned FB     = nnis_pkg::FRAC_BITS;
  localparam int unsigned CLW    = nnis_pkg::COLOR_W;
  localparam int unsigned PIXW   = nnis_pkg::PIXEL_W;
  localparam int unsigned COL_W  = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // Configuration and sequencing state.
  logic [SW-1:0]     src_w_r, src_h_r;
  logic [DW-1:0]     dst_w_r, dst_h_r;
  logic [COL_W-1:0]  load_col_r;
  logic [ROW_W-1:0]  load_row_r;
  logic [ADDR_W-1:0] load_base_r;
  logic              frame_full_r;
  logic [DW-1:0]     emit_col_r, emit_row_r;
  logic [STW-1:0]    col_step_r, row_step_r;

  // Lookup pipeline.
  logic [PW-1:0]     prod_x_r, prod_y_r;
  logic [COL_W-1:0]  sx_r;
  logic [ROW_W-1:0]  sy_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [PIXW-1:0]   rd_data_r;

  // Output register.
  logic              out_valid_r;
  logic [CLW-1:0]    red_r, green_r, blue_r;
  logic              row_end_r, frame_end_r;

  logic [PIXW-1:0]   mem [DEPTH];

  logic              cfg_hit;
  logic              load_take;
  logic              load_last_col, load_last_row;
  logic              emit_last_col, emit_last_row;
  logic [CW-1:0]     coord_x, coord_y;
  logic [COL_W-1:0]  sx_nxt;
  logic [ROW_W-1:0]  sy_nxt;
  logic [STW-1:0]    div_num;
  logic [DW-1:0]     div_den;
  logic              div_busy;
  logic [STW-1:0]    div_quo;
  logic [STW-1:0]    step_nxt;

  assign cfg_hit   = cfg_we && (cfg_index <= nnis_pkg::REG_TARGET_HEIGHT);
  assign load_take = cmd.in_take && (in_func == nnis_pkg::FUNC_LOAD);

  assign load_last_col = (32'(load_col_r) + 32'd1 >= 32'(src_w_r));
  assign load_last_row = (32'(load_row_r) + 32'd1 >= 32'(src_h_r));
  assign emit_last_col = (32'(emit_col_r) + 32'd1 >= 32'(dst_w_r));
  assign emit_last_row = (32'(emit_row_r) + 32'd1 >= 32'(dst_h_r));

  assign sts.cfg_hit    = cfg_hit;
  assign sts.in_valid   = in_valid;
  assign sts.in_fetch   = (in_func == nnis_pkg::FUNC_FETCH);
  assign sts.frame_full = frame_full_r;
  assign sts.div_busy   = div_busy;
  assign sts.out_free   = !out_valid_r || out_ch.ready;

  // Step divider, shared by both axes.
  assign div_num  = cmd.div_row ? {src_h_r, FB'(0)} : {src_w_r, FB'(0)};
  assign div_den  = cmd.div_row ? dst_h_r : dst_w_r;
  assign step_nxt = div_quo + STW'(1);

  nnis_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.col_step_load) col_step_r <= step_nxt;
    if (cmd.row_step_load) row_step_r <= step_nxt;
  end

  // Dimensions, counters and the frame-full flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r      <= nnis_pkg::clamp_src(SW'(nnis_pkg::DIM_RESET), MAX_SRC_WIDTH);
      src_h_r      <= nnis_pkg::clamp_src(SW'(nnis_pkg::DIM_RESET), MAX_SRC_HEIGHT);
      dst_w_r      <= nnis_pkg::clamp_dst(DW'(nnis_pkg::DIM_RESET), MAX_DST_SIZE);
      dst_h_r      <= nnis_pkg::clamp_dst(DW'(nnis_pkg::DIM_RESET), MAX_DST_SIZE);
      load_col_r   <= '0;
      load_row_r   <= '0;
      load_base_r  <= '0;
      frame_full_r <= 1'b0;
      emit_col_r   <= '0;
      emit_row_r   <= '0;
    end else if (cfg_hit) begin
      emit_col_r <= '0;
      emit_row_r <= '0;
      case (nnis_pkg::cfg_reg_t'(cfg_index))
        nnis_pkg::REG_SOURCE_WIDTH: begin
          src_w_r      <= nnis_pkg::clamp_src(cfg_wdata[SW-1:0], MAX_SRC_WIDTH);
          load_col_r   <= '0;
          load_row_r   <= '0;
          load_base_r  <= '0;
          frame_full_r <= 1'b0;
        end
        nnis_pkg::REG_SOURCE_HEIGHT: begin
          src_h_r      <= nnis_pkg::clamp_src(cfg_wdata[SW-1:0], MAX_SRC_HEIGHT);
          load_col_r   <= '0;
          load_row_r   <= '0;
          load_base_r  <= '0;
          frame_full_r <= 1'b0;
        end
        nnis_pkg::REG_TARGET_WIDTH: begin
          dst_w_r <= nnis_pkg::clamp_dst(cfg_wdata, MAX_DST_SIZE);
        end
        nnis_pkg::REG_TARGET_HEIGHT: begin
          dst_h_r <= nnis_pkg::clamp_dst(cfg_wdata, MAX_DST_SIZE);
        end
        default: begin
          dst_h_r <= dst_h_r;
        end
      endcase
    end else begin
      if (load_take) begin
        if (load_last_col) begin
          load_col_r <= '0;
          if (load_last_row) begin
            load_row_r   <= '0;
            load_base_r  <= '0;
            frame_full_r <= 1'b1;
          end else begin
            load_row_r  <= load_row_r + ROW_W'(1);
            load_base_r <= load_base_r + ADDR_W'(MAX_SRC_WIDTH);
          end
        end else begin
          load_col_r <= load_col_r + COL_W'(1);
        end
      end
      if (cmd.out_load) begin
        if (emit_last_col) begin
          emit_col_r <= '0;
          emit_row_r <= emit_last_row ? '0 : emit_row_r + DW'(1);
        end else begin
          emit_col_r <= emit_col_r + DW'(1);
        end
      end
    end
  end

  // Frame store: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (load_take) begin
      mem[load_base_r + ADDR_W'(load_col_r)] <= {in_red, in_green, in_blue};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  // Destination to source coordinate mapping.
  assign coord_x = prod_x_r[PW-1:FB];
  assign coord_y = prod_y_r[PW-1:FB];
  assign sx_nxt  = (coord_x >= CW'(src_w_r)) ? COL_W'(src_w_r - SW'(1)) : COL_W'(coord_x);
  assign sy_nxt  = (coord_y >= CW'(src_h_r)) ? ROW_W'(src_h_r - SW'(1)) : ROW_W'(coord_y);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_x_r <= PW'(emit_col_r) * PW'(col_step_r);
      prod_y_r <= PW'(emit_row_r) * PW'(row_step_r);
    end
    if (cmd.clamp_en) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
    if (cmd.addr_en) begin
      rd_addr_r <= ADDR_W'(sy_r) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(sx_r);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red_r       <= rd_data_r[PIXW-1 -: CLW];
      green_r     <= rd_data_r[CLW +: CLW];
      blue_r      <= rd_data_r[CLW-1:0];
      row_end_r   <= emit_last_col;
      frame_end_r <= emit_last_col && emit_last_row;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = red_r;
  assign out_ch.green_out = green_r;
  assign out_ch.blue_out  = blue_r;
  assign out_ch.row_end   = row_end_r;
  assign out_ch.frame_end = frame_end_r;

endmodule

// ===== rtl/core/nearest_neighbor_image_scaler_unit.sv =====
// Nearest-neighbor image scaler. Load words (func 0) write source pixels
// into an on-chip frame store in raster order; fetch words (func 1) return
// the next destination pixel in raster order, taken from source column
// min((x * column_step) >> 16, source_width - 1) and the matching row.
// Fetches give no word until a whole source frame has been loaded.
// Loads are taken one per clock while the block is idle. A served fetch
// passes through accept, multiply, clamp, address, store read and output
// load, and no new word is taken before its output load; the output
// register lets the next word in while a result waits. The step for each
// axis is computed by a shared serial divider, one bit per clock: after reset
// and after every dimension write the input stays stalled until both are done.
// Write configuration only while the block is idle.
module nearest_neighbor_image_scaler_unit #(
  parameter int unsigned MAX_SRC_WIDTH  = nnis_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = nnis_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned MAX_DST_SIZE   = nnis_pkg::DEF_MAX_DST_SIZE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  nnis_in_if.sink                         in_ch,
  nnis_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  nnis_pkg::cmd_t    cmd;
  nnis_pkg::status_t sts;

  // The sequencer owns the input handshake.
  assign in_ch.ready = cmd.in_ready;

  nnis_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  nnis_datapath #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .MAX_DST_SIZE   (MAX_DST_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_red    (in_ch.red_in),
    .in_green  (in_ch.green_in),
    .in_blue   (in_ch.blue_in),
    .cmd       (cmd),
    .sts       (sts),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/core/nnis_checker.sv =====
module nnis_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [nnis_pkg::COLOR_W-1:0]    out_red,
  input logic [nnis_pkg::COLOR_W-1:0]    out_green,
  input logic [nnis_pkg::COLOR_W-1:0]    out_blue,
  input logic                            out_row_end,
  input logic                            out_frame_end,
  input logic                            cfg_we,
  input logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index
);

  // A stalled result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_row_end) && $stable(out_frame_end))
    else $error("result word changed while stalled");

  // A dimension write starts a step recomputation, so input must stall.
  a_cfg_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index <= nnis_pkg::REG_TARGET_HEIGHT) |=> !in_ready)
    else $error("input accepted during step recomputation");

  // Reset leaves no result pending and the input stalled for the step setup.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

bind nearest_neighbor_image_scaler_unit nnis_checker u_nnis_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_red       (out_ch.red_out),
  .out_green     (out_ch.green_out),
  .out_blue      (out_ch.blue_out),
  .out_row_end   (out_ch.row_end),
  .out_frame_end (out_ch.frame_end),
  .cfg_we        (cfg_we),
  .cfg_index     (cfg_index)
);
